// ===== rtl/psc_pkg.sv =====
package psc_pkg;

  localparam int unsigned RAW_W   = 24;
  localparam int unsigned COEFF_W = 16;
  localparam int unsigned TEMP_W  = 19;
  localparam int unsigned PRES_W  = 32;
  localparam int unsigned IDX_W   = 3;

  // register indexes on the configuration port
  localparam logic [IDX_W-1:0] REG_MODEL       = 3'd0;
  localparam logic [IDX_W-1:0] REG_SENS        = 3'd1;
  localparam logic [IDX_W-1:0] REG_OFF         = 3'd2;
  localparam logic [IDX_W-1:0] REG_SENS_TEMP   = 3'd3;
  localparam logic [IDX_W-1:0] REG_OFF_TEMP    = 3'd4;
  localparam logic [IDX_W-1:0] REG_REF_TEMP    = 3'd5;
  localparam logic [IDX_W-1:0] REG_TEMP_SLOPE  = 3'd6;

  // model codes
  localparam logic MODEL_30BAR = 1'b0;
  localparam logic MODEL_2BAR  = 1'b1;

  localparam logic signed [63:0] TEMP_BASE  = 64'sd2000;
  localparam logic signed [19:0] TEMP_VLOW  = 20'sd1500;
  // temp/100 < 20 and temp/100 < -15 with truncating division
  localparam logic signed [TEMP_W-1:0] LOW_LIMIT  = 19'sd2000;
  localparam logic signed [TEMP_W-1:0] VLOW_LIMIT = -19'sd1599;

  // reciprocals for unsigned 32-bit divide by 10 and by 100
  localparam logic [31:0] DIV10_MAGIC  = 32'hCCCC_CCCD;
  localparam logic [5:0]  DIV10_SHIFT  = 6'd35;
  localparam logic [31:0] DIV100_MAGIC = 32'h51EB_851F;
  localparam logic [5:0]  DIV100_SHIFT = 6'd37;

  // signed divide by 2^k, truncating toward zero
  function automatic logic signed [63:0] sdiv_pow2(input logic signed [63:0] x,
                                                   input logic [5:0] k);
    logic signed [63:0] bias;
    bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
    return (x + bias) >>> k;
  endfunction

endpackage

// ===== rtl/pressure_sensor_compensation_top.sv =====
// channel   direction  handshake               payload
// in_       input      in_valid / in_stall     in_raw_pressure, in_raw_temperature
// out_      output     out_valid / out_stall   out_temperature_centi, out_pressure_mbar
// cfg_      input      cfg_we                  cfg_index, cfg_data
//
// twelve-stage pipeline: one word accepted per cycle unless in_stall is raised
// the stage count is set by the 24x40 pressure product split over two stages and the
// reciprocal multiply for the final divide by 10 or 100
// rst_n is synchronous and clears the valid bits and the calibration registers
// a word held at the output under out_stall freezes every stage and raises in_stall
module pressure_sensor_compensation_top
  import psc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [RAW_W-1:0]         in_raw_pressure,
  input  logic [RAW_W-1:0]         in_raw_temperature,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [TEMP_W-1:0] out_temperature_centi,
  output logic signed [PRES_W-1:0] out_pressure_mbar,
  input  logic                     cfg_we,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [COEFF_W-1:0]       cfg_data
);

  localparam int unsigned NSTAGE = 12;

  logic               model_r;
  logic [COEFF_W-1:0] c1_r, c2_r, c3_r, c4_r, c5_r, c6_r;

  logic [NSTAGE-1:0] valid_r;
  logic              adv;

  assign adv       = !(valid_r[NSTAGE-1] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = valid_r[NSTAGE-1];

  // calibration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      model_r <= MODEL_30BAR;
      c1_r    <= '0;
      c2_r    <= '0;
      c3_r    <= '0;
      c4_r    <= '0;
      c5_r    <= '0;
      c6_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODEL:      model_r <= cfg_data[0];
        REG_SENS:       c1_r    <= cfg_data;
        REG_OFF:        c2_r    <= cfg_data;
        REG_SENS_TEMP:  c3_r    <= cfg_data;
        REG_OFF_TEMP:   c4_r    <= cfg_data;
        REG_REF_TEMP:   c5_r    <= cfg_data;
        REG_TEMP_SLOPE: c6_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (adv) begin
      valid_r <= {valid_r[NSTAGE-2:0], in_valid};
    end
  end

  // stage 1: dT
  logic [RAW_W-1:0]   s1_d1_r;
  logic signed [24:0] s1_dt_r, s1_dt_nxt;
  assign s1_dt_nxt = $signed({1'b0, in_raw_temperature}) - $signed({1'b0, c5_r, 8'h00});

  // stage 2: first products of dT
  logic [RAW_W-1:0]   s2_d1_r;
  logic signed [41:0] s2_c3dt_r, s2_c4dt_r, s2_c6dt_r;
  logic [48:0]        s2_dtsq_r;
  logic signed [49:0] s2_dtsq_full;
  assign s2_dtsq_full = s1_dt_r * s1_dt_r;

  // stage 3: first-order temp, sens, off
  logic [RAW_W-1:0]          s3_d1_r;
  logic [48:0]               s3_dtsq_r;
  logic signed [TEMP_W-1:0]  s3_temp_r, s3_temp_nxt;
  logic signed [39:0]        s3_sens_r, s3_sens_nxt;
  logic signed [41:0]        s3_off_r, s3_off_nxt;

  always_comb begin
    logic [63:0] c1sh;
    logic [63:0] c2sh;
    logic signed [63:0] t64;
    logic signed [63:0] sens64;
    logic signed [63:0] off64;
    c1sh = {48'h0, c1_r} << ((model_r == MODEL_2BAR) ? 16 : 15);
    c2sh = {48'h0, c2_r} << ((model_r == MODEL_2BAR) ? 17 : 16);
    t64 = sdiv_pow2(64'(s2_c6dt_r), 6'd23) + TEMP_BASE;
    sens64 = $signed(c1sh) +
             sdiv_pow2(64'(s2_c3dt_r), (model_r == MODEL_2BAR) ? 6'd7 : 6'd8);
    off64 = $signed(c2sh) +
            sdiv_pow2(64'(s2_c4dt_r), (model_r == MODEL_2BAR) ? 6'd6 : 6'd7);
    s3_temp_nxt = t64[TEMP_W-1:0];
    s3_sens_nxt = sens64[39:0];
    s3_off_nxt  = off64[41:0];
  end

  // stage 4: squares of the temperature offsets
  logic [RAW_W-1:0]         s4_d1_r;
  logic [48:0]              s4_dtsq_r;
  logic signed [TEMP_W-1:0] s4_temp_r;
  logic signed [39:0]       s4_sens_r;
  logic signed [41:0]       s4_off_r;
  logic [39:0]              s4_sqm_r, s4_sqp_r;
  logic                     s4_low_r, s4_vlow_r;
  logic signed [19:0]       tm, tp;
  logic signed [39:0]       sqm_full, sqp_full;

  assign tm = 20'(s3_temp_r) - 20'(TEMP_BASE);
  assign tp = 20'(s3_temp_r) + TEMP_VLOW;
  assign sqm_full = tm * tm;
  assign sqp_full = tp * tp;

  // stage 5: second-order corrections
  logic [RAW_W-1:0]         s5_d1_r;
  logic signed [TEMP_W-1:0] s5_temp_r;
  logic signed [39:0]       s5_sens_r;
  logic signed [41:0]       s5_off_r;
  logic [TEMP_W-1:0]        s5_ti_r, s5_ti_nxt;
  logic [40:0]              s5_offi_r, s5_offi_nxt;
  logic [40:0]              s5_sensi_r, s5_sensi_nxt;

  always_comb begin
    logic [63:0] dsq;
    logic [63:0] sm;
    logic [63:0] sp;
    logic [63:0] ti64;
    logic [63:0] offi64;
    logic [63:0] sensi64;
    dsq = 64'(s4_dtsq_r);
    sm  = 64'(s4_sqm_r);
    sp  = 64'(s4_sqp_r);
    ti64 = '0;
    offi64 = '0;
    sensi64 = '0;
    if (model_r == MODEL_2BAR) begin
      if (s4_low_r) begin
        ti64    = (dsq * 64'd11) >> 35;
        offi64  = (sm * 64'd31) >> 3;
        sensi64 = (sm * 64'd63) >> 5;
      end
    end else begin
      if (s4_low_r) begin
        ti64    = (dsq * 64'd3) >> 33;
        offi64  = (sm * 64'd3) >> 1;
        sensi64 = (sm * 64'd5) >> 3;
        if (s4_vlow_r) begin
          offi64  = offi64 + sp * 64'd7;
          sensi64 = sensi64 + (sp << 2);
        end
      end else begin
        ti64   = (dsq << 1) >> 37;
        offi64 = sm >> 4;
      end
    end
    s5_ti_nxt    = ti64[TEMP_W-1:0];
    s5_offi_nxt  = offi64[40:0];
    s5_sensi_nxt = sensi64[40:0];
  end

  // stage 6: apply corrections
  logic [RAW_W-1:0]         s6_d1_r;
  logic signed [TEMP_W-1:0] s6_temp_r, s6_temp_nxt;
  logic signed [39:0]       s6_sens_r, s6_sens_nxt;
  logic signed [41:0]       s6_off_r, s6_off_nxt;

  assign s6_temp_nxt = s5_temp_r - $signed(s5_ti_r);
  assign s6_sens_nxt = 40'(42'(s5_sens_r) - $signed({1'b0, s5_sensi_r}));
  assign s6_off_nxt  = s5_off_r - $signed({1'b0, s5_offi_r});

  // stage 7: partial products of D1 * SENS
  logic signed [TEMP_W-1:0] s7_temp_r;
  logic signed [41:0]       s7_off_r;
  logic [43:0]              s7_plo_r, s7_plo_nxt;
  logic signed [44:0]       s7_phi_r, s7_phi_nxt;

  assign s7_plo_nxt = s6_d1_r * s6_sens_r[19:0];
  assign s7_phi_nxt = $signed({1'b0, s6_d1_r}) * $signed(s6_sens_r[39:20]);

  // stage 8: full product
  logic signed [TEMP_W-1:0] s8_temp_r;
  logic signed [41:0]       s8_off_r;
  logic signed [63:0]       s8_prod_r, s8_prod_nxt;

  assign s8_prod_nxt = (64'(s7_phi_r) <<< 20) + $signed({20'h0, s7_plo_r});

  // stage 9: scale and remove offset
  logic signed [TEMP_W-1:0] s9_temp_r;
  logic signed [47:0]       s9_y_r, s9_y_nxt;
  logic signed [63:0]       y64;

  assign y64      = sdiv_pow2(s8_prod_r, 6'd21) - 64'(s8_off_r);
  assign s9_y_nxt = y64[47:0];

  // stage 10: second scale, split sign and magnitude
  logic signed [TEMP_W-1:0] s10_temp_r;
  logic                     s10_neg_r, s10_neg_nxt;
  logic [31:0]              s10_mag_r, s10_mag_nxt;
  logic signed [63:0]       z64;
  logic signed [63:0]       zabs;

  assign z64 = sdiv_pow2(64'(s9_y_r), (model_r == MODEL_2BAR) ? 6'd15 : 6'd13);
  assign s10_neg_nxt = z64[63];
  assign zabs = z64[63] ? -z64 : z64;
  assign s10_mag_nxt = zabs[31:0];

  // stage 11: reciprocal multiply for the decimal divide
  logic signed [TEMP_W-1:0] s11_temp_r;
  logic                     s11_neg_r;
  logic [63:0]              s11_prod_r, s11_prod_nxt;

  assign s11_prod_nxt = 64'(s10_mag_r) *
                        64'((model_r == MODEL_2BAR) ? DIV100_MAGIC : DIV10_MAGIC);

  // stage 12: output word
  logic signed [TEMP_W-1:0] s12_temp_r;
  logic signed [PRES_W-1:0] s12_pres_r, s12_pres_nxt;

  always_comb begin
    logic [63:0] qsh;
    logic [32:0] q33;
    logic signed [32:0] p33;
    qsh = s11_prod_r >> ((model_r == MODEL_2BAR) ? DIV100_SHIFT : DIV10_SHIFT);
    q33 = {1'b0, qsh[31:0]};
    p33 = s11_neg_r ? -$signed(q33) : $signed(q33);
    if (p33[32] != p33[31]) begin
      // clamp to the signed 32-bit range
      s12_pres_nxt = p33[32] ? {1'b1, {(PRES_W-1){1'b0}}} : {1'b0, {(PRES_W-1){1'b1}}};
    end else begin
      s12_pres_nxt = p33[PRES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_d1_r    <= in_raw_pressure;
      s1_dt_r    <= s1_dt_nxt;

      s2_d1_r    <= s1_d1_r;
      s2_c3dt_r  <= $signed({1'b0, c3_r}) * s1_dt_r;
      s2_c4dt_r  <= $signed({1'b0, c4_r}) * s1_dt_r;
      s2_c6dt_r  <= $signed({1'b0, c6_r}) * s1_dt_r;
      s2_dtsq_r  <= s2_dtsq_full[48:0];

      s3_d1_r    <= s2_d1_r;
      s3_dtsq_r  <= s2_dtsq_r;
      s3_temp_r  <= s3_temp_nxt;
      s3_sens_r  <= s3_sens_nxt;
      s3_off_r   <= s3_off_nxt;

      s4_d1_r    <= s3_d1_r;
      s4_dtsq_r  <= s3_dtsq_r;
      s4_temp_r  <= s3_temp_r;
      s4_sens_r  <= s3_sens_r;
      s4_off_r   <= s3_off_r;
      s4_sqm_r   <= sqm_full;
      s4_sqp_r   <= sqp_full;
      s4_low_r   <= s3_temp_r < LOW_LIMIT;
      s4_vlow_r  <= s3_temp_r < VLOW_LIMIT;

      s5_d1_r    <= s4_d1_r;
      s5_temp_r  <= s4_temp_r;
      s5_sens_r  <= s4_sens_r;
      s5_off_r   <= s4_off_r;
      s5_ti_r    <= s5_ti_nxt;
      s5_offi_r  <= s5_offi_nxt;
      s5_sensi_r <= s5_sensi_nxt;

      s6_d1_r    <= s5_d1_r;
      s6_temp_r  <= s6_temp_nxt;
      s6_sens_r  <= s6_sens_nxt;
      s6_off_r   <= s6_off_nxt;

      s7_temp_r  <= s6_temp_r;
      s7_off_r   <= s6_off_r;
      s7_plo_r   <= s7_plo_nxt;
      s7_phi_r   <= s7_phi_nxt;

      s8_temp_r  <= s7_temp_r;
      s8_off_r   <= s7_off_r;
      s8_prod_r  <= s8_prod_nxt;

      s9_temp_r  <= s8_temp_r;
      s9_y_r     <= s9_y_nxt;

      s10_temp_r <= s9_temp_r;
      s10_neg_r  <= s10_neg_nxt;
      s10_mag_r  <= s10_mag_nxt;

      s11_temp_r <= s10_temp_r;
      s11_neg_r  <= s10_neg_r;
      s11_prod_r <= s11_prod_nxt;

      s12_temp_r <= s11_temp_r;
      s12_pres_r <= s12_pres_nxt;
    end
  end

  assign out_temperature_centi = s12_temp_r;
  assign out_pressure_mbar     = s12_pres_r;

endmodule
